### hw/rtl/deferred_push_min_heap_core_macros.svh
// Assertion macros for the deferred push min-heap core checker.
// Included by the checker file; no other dependency.
`ifndef DEFERRED_PUSH_MIN_HEAP_CORE_MACROS_SVH
`define DEFERRED_PUSH_MIN_HEAP_CORE_MACROS_SVH
// implication checked every clock outside reset
`define DPMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DPMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/dpmh_pkg.sv
// Package for the deferred push min-heap core: sizes, codes, state type, compare.
// No dependencies.
package dpmh_pkg;
    localparam int CAPACITY = 64;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W = ADDR_W + 1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP = 1'b1;

    typedef struct packed {
        logic signed [15:0] prio;
        logic signed [15:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_START,
        ST_UP_RD,
        ST_UP_CMP,
        ST_UP_NEXT,
        ST_POP_RD_ROOT,
        ST_POP_RD_LAST,
        ST_POP_WR_ROOT,
        ST_DN_RD_L,
        ST_DN_RD_R,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // true if a orders strictly before b
    function automatic logic entry_before(entry_t a, entry_t b);
        if (a.prio != b.prio)
            return a.prio < b.prio;
        return a.value < b.value;
    endfunction
endpackage

### hw/rtl/dpmh_if.sv
// Valid/ready channel interfaces for the deferred push min-heap core.
// Depends on nothing.
interface dpmh_req_if;
    logic valid;
    logic ready;
    logic action;
    logic signed [15:0] entry_priority;
    logic signed [15:0] entry_value;
    modport source (output valid, action, entry_priority, entry_value, input ready);
    modport sink (input valid, action, entry_priority, entry_value, output ready);
endinterface

interface dpmh_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic signed [15:0] out_priority;
    logic signed [15:0] out_value;
    logic [6:0] tail_position;
    logic [6:0] heap_count;
    logic [6:0] pending_count;
    modport source (output valid, status, out_priority, out_value, tail_position,
                    heap_count, pending_count, input ready);
    modport sink (input valid, status, out_priority, out_value, tail_position,
                  heap_count, pending_count, output ready);
endinterface

### hw/rtl/dpmh_ram.sv
// Single-port entry store with registered read.
// Depends on dpmh_pkg.
module dpmh_ram
    import dpmh_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  entry_t            wdata,
    output entry_t            rdata
);
    entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/deferred_push_min_heap_core.sv
// Top level of the deferred push min-heap core: sequencer around one entry store.
// Depends on dpmh_pkg, dpmh_if and dpmh_ram.
//
// A min-heap priority queue of CAPACITY 32-bit words (signed priority, signed
// value as tie-break). A push writes the word at the tail unless the queue is
// full, then raises its result; it is not sifted. A pop with an empty queue and
// nothing pending answers STATUS_EMPTY. Otherwise a pop first sifts every
// pending word up (ST_UP_CMP, ST_UP_NEXT per level it climbs), then reads the
// root and the last heap word and moves that word to the root (ST_POP_RD_ROOT,
// ST_POP_RD_LAST, ST_POP_WR_ROOT), then sifts it down (ST_DN_RD_L, ST_DN_RD_R,
// ST_DN_CMP per level it descends), and the result is raised from ST_DONE. The
// cost is set by the single-port entry store: one read or write per cycle. One
// word is in work at a time; the result is held in an output register until
// taken, and the input side is ready again the cycle after that.
module deferred_push_min_heap_core
    import dpmh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dpmh_req_if.sink   req,
    dpmh_rsp_if.source rsp
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] heap_reg, heap_next, tail_reg, tail_next;
    logic [ADDR_W-1:0] pos_reg, pos_next, best_reg, best_next;
    entry_t cur_reg, cur_next, bw_reg, bw_next;   // sifting word, best child word
    logic [1:0] status_reg, status_next;
    entry_t res_reg, res_next;
    logic rvalid_reg, rvalid_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_addr;
    entry_t ram_wdata, ram_rdata;

    dpmh_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
                    .rdata(ram_rdata));

    logic [ADDR_W-1:0] parent;
    logic [CNT_W:0] lchild, rchild;
    logic [CNT_W-1:0] heap_dec;
    assign parent = (pos_reg - 1'b1) >> 1;
    assign lchild = {1'b0, pos_reg, 1'b1};
    assign rchild = {1'b0, pos_reg, 1'b0} + (CNT_W+1)'(2);
    assign heap_dec = heap_reg - 1'b1;

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            heap_reg <= '0;
            tail_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            heap_reg <= heap_next;
            tail_reg <= tail_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        best_reg <= best_next;
        cur_reg <= cur_next;
        bw_reg <= bw_next;
        status_reg <= status_next;
        res_reg <= res_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        heap_next = heap_reg;
        tail_next = tail_reg;
        pos_next = pos_reg;
        best_next = best_reg;
        cur_next = cur_reg;
        bw_next = bw_reg;
        status_next = status_reg;
        res_next = res_reg;
        rvalid_next = rvalid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '0;
                    status_next = STATUS_OK;
                    if (req.action == ACTION_PUSH)
                    begin
                        if (tail_reg == CNT_W'(CAPACITY))
                            status_next = STATUS_FULL;
                        else
                            tail_next = tail_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_UP_START;
                end
            end
            ST_UP_START:
            begin
                // absorb next pending word, answer empty, or go pop
                if (tail_reg > heap_reg)
                begin
                    pos_next = heap_reg[ADDR_W-1:0];
                    heap_next = heap_reg + 1'b1;
                    state_next = ST_UP_RD;
                end
                else if (heap_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_POP_RD_ROOT;
            end
            ST_UP_RD:
            begin
                // ram returns the word at pos read last cycle; read parent next
                cur_next = ram_rdata;
                state_next = (pos_reg == '0) ? ST_UP_START : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (entry_before(cur_reg, ram_rdata))
                begin
                    // parent drops into pos; climb
                    pos_next = parent;
                    state_next = ST_UP_NEXT;
                end
                else
                    state_next = ST_UP_START;
            end
            ST_UP_NEXT:
                // at the root, park the word; else fetch the new parent
                state_next = (pos_reg == '0) ? ST_UP_START : ST_UP_CMP;
            ST_POP_RD_ROOT:
                state_next = ST_POP_RD_LAST;
            ST_POP_RD_LAST:
            begin
                res_next = ram_rdata;
                state_next = ST_POP_WR_ROOT;
            end
            ST_POP_WR_ROOT:
            begin
                cur_next = ram_rdata;
                heap_next = heap_dec;
                tail_next = heap_dec;
                pos_next = '0;
                state_next = ST_DN_RD_L;
            end
            ST_DN_RD_L:
            begin
                if (lchild >= (CNT_W+1)'(heap_reg))
                    state_next = ST_DONE;
                else
                    state_next = ST_DN_RD_R;
            end
            ST_DN_RD_R:
            begin
                best_next = lchild[ADDR_W-1:0];
                bw_next = ram_rdata;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                // ram_rdata is right child when it exists
                if (rchild < (CNT_W+1)'(heap_reg) && entry_before(ram_rdata, bw_reg))
                begin
                    if (entry_before(ram_rdata, cur_reg))
                    begin
                        pos_next = rchild[ADDR_W-1:0];
                        state_next = ST_DN_RD_L;
                    end
                    else
                        state_next = ST_DONE;
                end
                else if (entry_before(bw_reg, cur_reg))
                begin
                    pos_next = best_reg;
                    state_next = ST_DN_RD_L;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rvalid_reg)
                    rvalid_next = 1'b1;
                else if (rsp.ready)
                begin
                    rvalid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = pos_reg;
        ram_wdata = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = tail_reg[ADDR_W-1:0];
                ram_wdata = '{prio: req.entry_priority, value: req.entry_value};
                ram_we = req.valid && (req.action == ACTION_PUSH)
                         && (tail_reg != CNT_W'(CAPACITY));
            end
            ST_UP_START:
                ram_addr = heap_reg[ADDR_W-1:0];
            ST_UP_RD:
                ram_addr = parent;
            ST_UP_CMP:
            begin
                if (entry_before(cur_reg, ram_rdata))
                begin
                    // write parent down into pos; its slot is written again later
                    ram_we = 1'b1;
                    ram_addr = pos_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_we = 1'b1;
                    ram_addr = pos_reg;
                    ram_wdata = cur_reg;
                end
            end
            ST_UP_NEXT:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                    ram_addr = pos_reg;
                end
                else
                    ram_addr = parent;
            end
            ST_POP_RD_ROOT:
                ram_addr = '0;
            ST_POP_RD_LAST:
                ram_addr = heap_dec[ADDR_W-1:0];
            ST_POP_WR_ROOT:
                ram_addr = '0;
            ST_DN_RD_L:
            begin
                if (lchild >= (CNT_W+1)'(heap_reg))
                begin
                    ram_we = (heap_reg != '0);
                    ram_addr = pos_reg;
                end
                else
                    ram_addr = lchild[ADDR_W-1:0];
            end
            ST_DN_RD_R:
                ram_addr = (rchild < (CNT_W+1)'(heap_reg)) ? rchild[ADDR_W-1:0]
                                                           : lchild[ADDR_W-1:0];
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                ram_addr = pos_reg;
                if (rchild < (CNT_W+1)'(heap_reg) && entry_before(ram_rdata, bw_reg))
                    ram_wdata = entry_before(ram_rdata, cur_reg) ? ram_rdata : cur_reg;
                else
                    ram_wdata = entry_before(bw_reg, cur_reg) ? bw_reg : cur_reg;
            end
            default:
                ram_addr = pos_reg;
        endcase
    end

    assign rsp.valid = rvalid_reg;
    assign rsp.status = status_reg;
    assign rsp.out_priority = res_reg.prio;
    assign rsp.out_value = res_reg.value;
    assign rsp.tail_position = 7'(tail_reg);
    assign rsp.heap_count = 7'(heap_reg);
    assign rsp.pending_count = 7'(tail_reg - heap_reg);
endmodule

### hw/rtl/dpmh_checker.sv
// Port-level checker for the deferred push min-heap core, with its bind.
// Depends on the macros header and dpmh_pkg.
`include "deferred_push_min_heap_core_macros.svh"
module dpmh_checker
    import dpmh_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [6:0] tail_position,
    input logic [6:0] heap_count,
    input logic [6:0] pending_count
);
    `DPMH_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `DPMH_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(tail_position) && $stable(heap_count))
    `DPMH_ASSERT_IMP(a_pending_sum, clk, rst_n, out_valid, pending_count == 7'(tail_position - heap_count))
    `DPMH_ASSERT_IMP(a_pop_clears_pending, clk, rst_n, out_valid && status == STATUS_EMPTY, tail_position == 7'd0)
    `DPMH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind deferred_push_min_heap_core dpmh_checker u_dpmh_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(rsp.status), .tail_position(rsp.tail_position),
    .heap_count(rsp.heap_count), .pending_count(rsp.pending_count)
);
